>>> hdl/fraction_precision_shrink_core_assert.svh
// Assertion macros shared by the fraction precision shrink RTL.
`ifndef FRACTION_PRECISION_SHRINK_CORE_ASSERT_SVH
`define FRACTION_PRECISION_SHRINK_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fps assertion failed");

// Next-cycle implication, checked outside reset.
`define FPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fps assertion failed");

`endif

>>> hdl/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// Types, constants and helper functions of the fraction precision shrink core.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int DATA_W = 64;
  localparam int BLEN_W = 7;
  localparam int CELLS = DATA_W;

  localparam logic signed [7:0] SHRINK_SPAN = 8'sd24;
  // Any magnitude bit at position 31 or above means a bit length of 32 or more.
  localparam logic [BLEN_W-1:0] HIGH_BITLEN = 7'd32;
  localparam logic [3:0] TOP_NIBBLE = 4'd15;
  localparam logic [3:0] BASE_NIBBLE = 4'd7;

  typedef struct packed {
    logic [DATA_W-1:0] numerator;
    logic [DATA_W-1:0] denominator;
  } fps_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] new_numerator;
    logic [DATA_W-1:0] new_denominator;
    logic              divide_fault;
  } fps_out_t;

  typedef struct packed {
    logic [DATA_W-1:0] res_n;
    logic [DATA_W-1:0] res_d;
    logic              fault;
    logic              use_q;
    logic              q_to_num;
    logic              neg;
  } meta_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] dq;
    logic [DATA_W-1:0] dv;
    meta_t             meta;
  } cell_t;

  function automatic logic [DATA_W-1:0] with_sign(input logic [DATA_W-1:0] mag,
                                                  input logic neg);
    with_sign = neg ? (DATA_W'(0) - mag) : mag;
  endfunction

  function automatic logic [BLEN_W-1:0] bit_length(input logic [DATA_W-1:0] x);
    logic [BLEN_W-1:0] r;
    r = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (x[i]) r = BLEN_W'(i + 1);
    end
    bit_length = r;
  endfunction

endpackage

>>> hdl/fps_front.sv
// ----------------------------------------------------------------------------
// fps_front
// Two input stages: magnitudes, then case decode and divider operand setup.
// ----------------------------------------------------------------------------
module fps_front import fps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  fps_in_t in_data,
  output cell_t   cout
);

  logic              a_valid;
  logic [DATA_W-1:0] a_n;
  logic [DATA_W-1:0] a_d;
  logic [DATA_W-1:0] a_nraw;
  logic [DATA_W-1:0] a_draw;
  logic              a_nneg;
  logic              a_dneg;

  logic [BLEN_W-1:0] bln;
  logic [BLEN_W-1:0] bld;
  logic [BLEN_W-1:0] blo;
  logic signed [7:0] k;
  logic [3:0]        p;
  logic [6:0]        s;
  cell_t             cout_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_nraw <= in_data.numerator;
      a_draw <= in_data.denominator;
      a_nneg <= in_data.numerator[DATA_W-1];
      a_dneg <= in_data.denominator[DATA_W-1];
      a_n    <= with_sign(in_data.numerator, in_data.numerator[DATA_W-1]);
      a_d    <= with_sign(in_data.denominator, in_data.denominator[DATA_W-1]);
    end
  end

  always_comb begin
    bln = bit_length(a_n);
    bld = bit_length(a_d);
    blo = bit_length(a_n | a_d);
    k   = $signed({1'b0, bln}) - $signed({1'b0, bld});
    // Nibble index is bit length / 4, clamped when bit 63 is set.
    p   = (blo[6:2] > {1'b0, TOP_NIBBLE}) ? TOP_NIBBLE : blo[5:2];
    s   = {1'b0, p - BASE_NIBBLE, 2'b00};

    cout_next                = '0;
    cout_next.valid          = a_valid;
    cout_next.dq             = a_n;
    cout_next.dv             = a_d;
    cout_next.meta.res_n     = a_nraw;
    cout_next.meta.res_d     = a_draw;
    cout_next.meta.neg       = a_nneg ^ a_dneg;

    if (k < -SHRINK_SPAN) begin
      if (a_n != '0) begin
        cout_next.meta.use_q = 1'b1;
        cout_next.dq         = a_d;
        cout_next.dv         = a_n;
      end else begin
        cout_next.meta.res_d = DATA_W'(1);
      end
    end else if (k > SHRINK_SPAN) begin
      if (a_d == '0) begin
        cout_next.meta.fault    = 1'b1;
      end else begin
        cout_next.meta.use_q    = 1'b1;
        cout_next.meta.q_to_num = 1'b1;
      end
    end else if (blo >= HIGH_BITLEN) begin
      cout_next.meta.res_n = with_sign(a_n >> s, a_nneg);
      cout_next.meta.res_d = with_sign(a_d >> s, a_dneg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else if (en) begin
      cout.valid <= cout_next.valid;
    end
    if (en) begin
      cout.rem  <= cout_next.rem;
      cout.dq   <= cout_next.dq;
      cout.dv   <= cout_next.dv;
      cout.meta <= cout_next.meta;
    end
  end

endmodule

>>> hdl/fps_cell.sv
// ----------------------------------------------------------------------------
// fps_cell
// One restoring-division step: develops one quotient bit and passes it on.
// ----------------------------------------------------------------------------
module fps_cell import fps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t cin,
  output cell_t cout
);

  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;
  logic              ge;

  always_comb begin
    shifted = {cin.rem, cin.dq[DATA_W-1]};
    diff    = {1'b0, shifted} - {2'b00, cin.dv};
    ge      = !diff[DATA_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else if (en) begin
      cout.valid <= cin.valid;
    end
    if (en) begin
      // The remainder stays below the divisor, so it fits in DATA_W bits.
      cout.rem  <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      cout.dq   <= {cin.dq[DATA_W-2:0], ge};
      cout.dv   <= cin.dv;
      cout.meta <= cin.meta;
    end
  end

endmodule

>>> hdl/fraction_precision_shrink_core.sv
// ----------------------------------------------------------------------------
// fraction_precision_shrink_core
// Shrinks a signed 64-bit fraction to a coarser one of about the same value.
// ----------------------------------------------------------------------------
// Usage: present numerator and denominator on in_data with in_valid; a
// transaction completes when in_valid and in_ready are both high. Results
// leave on out_data with out_valid and complete when out_ready is high.
// Each result passes through two decode stages, a chain of 64 division
// cells (one quotient bit per cell) and the output register. One
// transaction is taken every cycle while the output flows.
// When the receiver stalls with a result waiting, the whole chain holds
// and in_ready drops until the result is taken. A synchronous reset empties
// every stage; no result is pending afterwards. A zero denominator in the
// integer-part case passes the input through with divide_fault set.
// ----------------------------------------------------------------------------
module fraction_precision_shrink_core import fps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  fps_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fps_out_t out_data
);

`include "fraction_precision_shrink_core_assert.svh"

  logic              adv;
  cell_t             chain [CELLS+1];
  cell_t             last;
  logic [DATA_W-1:0] qv;
  fps_out_t          out_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  fps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cout     (chain[0])
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    fps_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .cin  (chain[i]),
      .cout (chain[i+1])
    );
  end

  assign last = chain[CELLS];

  always_comb begin
    qv       = with_sign(last.dq, last.meta.neg);
    out_next = '{new_numerator:   last.meta.res_n,
                 new_denominator: last.meta.res_d,
                 divide_fault:    last.meta.fault};
    if (last.meta.use_q) begin
      if (last.meta.q_to_num) begin
        out_next.new_numerator   = qv;
        out_next.new_denominator = DATA_W'(1);
      end else begin
        out_next.new_numerator   = DATA_W'(1);
        out_next.new_denominator = qv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= last.valid;
    end
    if (adv) begin
      out_data <= out_next;
    end
  end

  `FPS_ASSERT_NOW(a_fault_zero_den, out_valid && out_data.divide_fault, out_data.new_denominator == '0)
  `FPS_ASSERT_NOW(a_fault_num_set, out_valid && out_data.divide_fault, out_data.new_numerator != '0)
  `FPS_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule
